FILE: design/fsjr_pkg.sv
// Package for the feeder step and jam recovery sequencer.
// Holds the transaction payload types, configuration types, codes and defaults.
// No dependencies.
package fsjr_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_JAM_TIMEOUT   = 3'd0;
  localparam logic [2:0] CFG_BACKOFF_TIME  = 3'd1;
  localparam logic [2:0] CFG_RETREAT_ANGLE = 3'd2;
  localparam logic [2:0] CFG_RAPID_STEP    = 3'd3;
  localparam logic [2:0] CFG_SINGLE_STEP   = 3'd4;
  localparam logic [2:0] CFG_SETTLE_TOL    = 3'd5;
  localparam logic [2:0] CFG_STALL_SPEED   = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register defaults
  localparam logic [15:0] JAM_TIMEOUT_RST   = 16'd500;
  localparam logic [15:0] BACKOFF_TIME_RST  = 16'd500;
  localparam logic [15:0] RETREAT_ANGLE_RST = 16'd960;
  localparam logic [15:0] RAPID_STEP_RST    = 16'd320;
  localparam logic [15:0] SINGLE_STEP_RST   = 16'd960;
  localparam logic [11:0] SETTLE_TOL_RST    = 12'd48;
  localparam logic [14:0] STALL_SPEED_RST   = 15'd5000;

  // Run mode codes
  localparam logic [1:0] MODE_RELAX = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Fire command codes
  localparam logic [1:0] FIRE_NONE   = 2'd0;
  localparam logic [1:0] FIRE_SINGLE = 2'd1;
  localparam logic [1:0] FIRE_RAPID  = 2'd2;
  localparam logic [1:0] FIRE_STOP   = 2'd3;

  // Feed state codes as seen on the result channel
  localparam logic [2:0] FEED_IDLE  = 3'd0;
  localparam logic [2:0] FEED_BEGIN = 3'd1;
  localparam logic [2:0] FEED_STEP  = 3'd2;
  localparam logic [2:0] FEED_RAPID = 3'd3;
  localparam logic [2:0] FEED_BACK  = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         shot_req;
    logic signed [31:0] measured_angle;
    logic [31:0]        now_ms;
    logic signed [15:0] motor_rpm;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] target_angle;
    logic [2:0]         feed_state;
  } out_item_t;

  typedef struct packed {
    logic [15:0] jam_timeout_ms;
    logic [15:0] backoff_time_ms;
    logic [15:0] retreat_angle;
    logic [15:0] rapid_step_angle;
    logic [15:0] single_step_angle;
    logic [11:0] settle_tolerance;
    logic [14:0] stall_speed_rpm;
  } cfg_t;

  // Saturate a 33 bit signed sum to the signed 32 bit range
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/fsjr_core.sv
// Sequencer core: phase machine, set point and move timestamp, plus result register.
// Depends on fsjr_pkg.
module fsjr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  fsjr_pkg::in_item_t item,
  input  fsjr_pkg::cfg_t    cfg,
  output fsjr_pkg::out_item_t res
);
  import fsjr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = FEED_IDLE,
    PH_BEGIN = FEED_BEGIN,
    PH_STEP  = FEED_STEP,
    PH_RAPID = FEED_RAPID,
    PH_BACK  = FEED_BACK
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic signed [31:0] goal_r, goal_nxt;
  logic [31:0]        start_r, start_nxt;
  out_item_t          res_r;

  logic signed [32:0] meas_x;
  logic signed [31:0] single_goal, rapid_goal, back_goal;
  logic signed [32:0] err;
  logic [32:0]        abs_err;
  logic               settled;
  logic [31:0]        elapsed;
  logic               jam_to, back_to, slow;

  // Candidate set points, saturated
  assign meas_x      = {item.measured_angle[31], item.measured_angle};
  assign single_goal = sat33(meas_x - $signed({17'b0, cfg.single_step_angle}));
  assign rapid_goal  = sat33(meas_x - $signed({17'b0, cfg.rapid_step_angle}));
  assign back_goal   = sat33(meas_x + $signed({17'b0, cfg.retreat_angle}));

  // Settle check: |goal - measured| < tolerance
  assign err     = $signed({goal_r[31], goal_r}) - meas_x;
  assign abs_err = err[32] ? 33'(-err) : 33'(err);
  assign settled = abs_err < {21'b0, cfg.settle_tolerance};

  // Timeouts on wrapping ms counter
  assign elapsed = item.now_ms - start_r;
  assign jam_to  = elapsed > {16'b0, cfg.jam_timeout_ms};
  assign back_to = elapsed > {16'b0, cfg.backoff_time_ms};
  assign slow    = item.motor_rpm < $signed({1'b0, cfg.stall_speed_rpm});

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    goal_nxt  = goal_r;
    start_nxt = start_r;
    if (item.mode != MODE_START) begin
      phase_nxt = PH_IDLE;
      goal_nxt  = item.measured_angle;
    end else begin
      unique case (phase_r)
        PH_BEGIN: begin
          phase_nxt = PH_STEP;
          goal_nxt  = single_goal;
          start_nxt = item.now_ms;
        end
        PH_STEP: begin
          priority if (settled) begin
            phase_nxt = PH_IDLE;
          end else if (jam_to) begin
            phase_nxt = PH_BACK;
            goal_nxt  = back_goal;
            start_nxt = item.now_ms;
          end else begin
            phase_nxt = PH_STEP;
          end
        end
        PH_RAPID: begin
          goal_nxt = rapid_goal;
          priority if (jam_to) begin
            if (slow) begin
              phase_nxt = PH_BACK;
              goal_nxt  = back_goal;
              start_nxt = item.now_ms;
            end
          end else if (item.shot_req == FIRE_STOP) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_RAPID;
          end
        end
        PH_BACK: begin
          priority if (settled) begin
            phase_nxt = PH_BEGIN;
          end else if (back_to) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_BACK;
          end
        end
        default: begin
          // idle: only single shot or rapid fire leave
          priority if (item.shot_req == FIRE_SINGLE) begin
            phase_nxt = PH_BEGIN;
          end else if (item.shot_req == FIRE_RAPID) begin
            phase_nxt = PH_RAPID;
            start_nxt = item.now_ms;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      goal_r  <= '0;
      start_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      goal_r  <= goal_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.target_angle <= goal_nxt;
      res_r.feed_state   <= phase_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: design/feeder_step_jam_recovery_fsm.sv
// Feeder step and jam recovery sequencer, top level.
// An input transaction passes the input register, then the core result register.
// Throughput: one transaction per cycle unless a result is held (single core stage).
// A held result stalls the input register; input stays ready while the output drains.
// Reset (synchronous, rst_n low): registers to defaults, phase idle, set point
// and move stamp zero, pipeline empty. Depends on fsjr_pkg and fsjr_core.
module feeder_step_jam_recovery_fsm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fsjr_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fsjr_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [fsjr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsjr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fsjr_pkg::*;

  cfg_t     cfg_r;
  in_item_t s1_data_r;
  logic     s1_valid_r;
  logic     out_valid_r;
  logic     adv;

  // Handshake: core stage moves when the result register is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign out_valid = out_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jam_timeout_ms    <= JAM_TIMEOUT_RST;
      cfg_r.backoff_time_ms   <= BACKOFF_TIME_RST;
      cfg_r.retreat_angle     <= RETREAT_ANGLE_RST;
      cfg_r.rapid_step_angle  <= RAPID_STEP_RST;
      cfg_r.single_step_angle <= SINGLE_STEP_RST;
      cfg_r.settle_tolerance  <= SETTLE_TOL_RST;
      cfg_r.stall_speed_rpm   <= STALL_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_JAM_TIMEOUT:   cfg_r.jam_timeout_ms    <= cfg_wdata;
        CFG_BACKOFF_TIME:  cfg_r.backoff_time_ms   <= cfg_wdata;
        CFG_RETREAT_ANGLE: cfg_r.retreat_angle     <= cfg_wdata;
        CFG_RAPID_STEP:    cfg_r.rapid_step_angle  <= cfg_wdata;
        CFG_SINGLE_STEP:   cfg_r.single_step_angle <= cfg_wdata;
        CFG_SETTLE_TOL:    cfg_r.settle_tolerance  <= cfg_wdata[11:0];
        CFG_STALL_SPEED:   cfg_r.stall_speed_rpm   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  fsjr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_data_r),
    .cfg   (cfg_r),
    .res   (out_data)
  );

endmodule

FILE: design/fsjr_checker.sv
// Port-level checker for the feeder sequencer, with its bind to the top level.
// Depends on fsjr_pkg.
module fsjr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input fsjr_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_ready
);
  import fsjr_pkg::*;

  logic [2:0] prev_state_r;
  logic       have_prev_r;

  // Track the state of the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      prev_state_r <= FEED_IDLE;
    end else if (out_valid && out_ready) begin
      have_prev_r  <= 1'b1;
      prev_state_r <= out_data.feed_state;
    end
  end

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with result side free");

  // Begin always leads to stepping, or to idle when stopped
  a_begin_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && have_prev_r && prev_state_r == FEED_BEGIN |->
      out_data.feed_state == FEED_STEP || out_data.feed_state == FEED_IDLE)
    else $error("bad transition out of begin");

  // Stepping is only reached through begin
  a_step_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && have_prev_r && out_data.feed_state == FEED_STEP |->
      prev_state_r == FEED_BEGIN || prev_state_r == FEED_STEP)
    else $error("stepping entered without begin");

endmodule

bind feeder_step_jam_recovery_fsm fsjr_checker u_fsjr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

FILE: dv/feeder_step_jam_recovery_fsm_test.sv
// Self-checking testbench for the feeder step and jam recovery sequencer.
// Drives ticks through the valid/ready input, predicts every result with an
// in-bench model of the phase machine and checks it. Depends on fsjr_pkg.
`timescale 1ns / 100ps

module feeder_step_jam_recovery_fsm_test;
  import fsjr_pkg::*;

  // Mode code that the block must treat as not running
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  feeder_step_jam_recovery_fsm dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pending ticks, expected set points, run statistics
  in_item_t feed_items[$];
  out_item_t feed_expect[$];
  int fail_count = 0;
  int n_in = 0;
  int n_out = 0;
  int n_settings = 0;
  int queued = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;

  // Idling controls, set per phase
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_order = 0;
  int hold_taken = 0;
  int hold_left = 0;

  // Mirror of the sequencer: registers, phase, set point, move stamp
  cfg_t regs = '{JAM_TIMEOUT_RST, BACKOFF_TIME_RST, RETREAT_ANGLE_RST, RAPID_STEP_RST,
                 SINGLE_STEP_RST, SETTLE_TOL_RST, STALL_SPEED_RST};
  logic [2:0] feed_phase = FEED_IDLE;
  logic signed [31:0] aim_angle = '0;
  logic [31:0] move_stamp = '0;

  // Stimulus generator state
  logic [31:0] gen_now = '0;
  logic signed [31:0] gen_pos = '0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic bit near_aim(logic signed [31:0] meas);
    longint e;
    e = longint'(aim_angle) - longint'(meas);
    if (e < 0) e = -e;
    return e < longint'(regs.settle_tolerance);
  endfunction

  // Elapsed time is modulo 2^32, so a counter wrap is harmless
  function automatic bit overdue(logic [31:0] now, logic [15:0] lim);
    logic [31:0] el;
    el = now - move_stamp;
    return el > {16'd0, lim};
  endfunction

  function automatic void start_reverse(logic signed [31:0] meas, logic [31:0] now);
    feed_phase = FEED_BACK;
    aim_angle = clamp32(longint'(meas) + longint'(regs.retreat_angle));
    move_stamp = now;
  endfunction

  // One control tick of the phase machine
  function automatic out_item_t advance_feeder(in_item_t t);
    out_item_t r;
    logic signed [31:0] meas;
    logic [31:0] now;
    meas = t.measured_angle;
    now = t.now_ms;
    if (t.mode != MODE_START) begin
      feed_phase = FEED_IDLE;
      aim_angle = meas;
    end else begin
      case (feed_phase)
        FEED_BEGIN: begin
          feed_phase = FEED_STEP;
          aim_angle = clamp32(longint'(meas) - longint'(regs.single_step_angle));
          move_stamp = now;
        end
        FEED_STEP: begin
          if (near_aim(meas)) feed_phase = FEED_IDLE;
          else if (overdue(now, regs.jam_timeout_ms)) start_reverse(meas, now);
        end
        FEED_RAPID: begin
          aim_angle = clamp32(longint'(meas) - longint'(regs.rapid_step_angle));
          // past the timeout only a slow motor counts as jammed; stop fire is ignored
          if (overdue(now, regs.jam_timeout_ms)) begin
            if (int'(t.motor_rpm) < int'(regs.stall_speed_rpm)) start_reverse(meas, now);
          end else if (t.shot_req == FIRE_STOP) begin
            feed_phase = FEED_IDLE;
          end
        end
        FEED_BACK: begin
          if (near_aim(meas)) feed_phase = FEED_BEGIN;
          else if (overdue(now, regs.backoff_time_ms)) feed_phase = FEED_IDLE;
        end
        default: begin
          feed_phase = FEED_IDLE;
          if (t.shot_req == FIRE_SINGLE) begin
            feed_phase = FEED_BEGIN;
          end else if (t.shot_req == FIRE_RAPID) begin
            feed_phase = FEED_RAPID;
            move_stamp = now;
          end
        end
      endcase
    end
    r.target_angle = aim_angle;
    r.feed_state = feed_phase;
    return r;
  endfunction

  // Input driver: payload held until the transaction is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (feed_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data <= feed_items.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_order != hold_taken) begin
      hold_taken = hold_order;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: predict on input, check on output, watch for a hang
  always @(posedge clk) begin : monitor
    out_item_t want;
    bit moved;
    moved = 1'b0;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        moved = 1'b1;
        feed_expect.push_back(advance_feeder(in_data));
        n_in++;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        n_out++;
        if (feed_expect.size() == 0) begin
          $error("unexpected result: target_angle %0d feed_state %0d",
                 out_data.target_angle, out_data.feed_state);
          fail_count++;
        end else begin
          want = feed_expect.pop_front();
          if (out_data.target_angle !== want.target_angle) begin
            $error("target_angle mismatch: expected %0d, got %0d",
                   want.target_angle, out_data.target_angle);
            fail_count++;
          end
          if (out_data.feed_state !== want.feed_state) begin
            $error("feed_state mismatch: expected %0d, got %0d",
                   want.feed_state, out_data.feed_state);
            fail_count++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** feeder_step_jam_recovery_fsm: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_JAM_TIMEOUT:   regs.jam_timeout_ms = val;
      CFG_BACKOFF_TIME:  regs.backoff_time_ms = val;
      CFG_RETREAT_ANGLE: regs.retreat_angle = val;
      CFG_RAPID_STEP:    regs.rapid_step_angle = val;
      CFG_SINGLE_STEP:   regs.single_step_angle = val;
      CFG_SETTLE_TOL:    regs.settle_tolerance = val[11:0];
      CFG_STALL_SPEED:   regs.stall_speed_rpm = val[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(CFG_JAM_TIMEOUT, c.jam_timeout_ms);
    write_reg(CFG_BACKOFF_TIME, c.backoff_time_ms);
    write_reg(CFG_RETREAT_ANGLE, c.retreat_angle);
    write_reg(CFG_RAPID_STEP, c.rapid_step_angle);
    write_reg(CFG_SINGLE_STEP, c.single_step_angle);
    write_reg(CFG_SETTLE_TOL, {4'd0, c.settle_tolerance});
    write_reg(CFG_STALL_SPEED, {1'b0, c.stall_speed_rpm});
    n_settings++;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    bit wide;
    wide = ($urandom_range(0, 3) == 0);
    c.jam_timeout_ms = 16'($urandom_range(20, 1500));
    c.backoff_time_ms = 16'($urandom_range(20, 1500));
    c.retreat_angle = wide ? 16'($urandom) : 16'($urandom_range(0, 4000));
    c.rapid_step_angle = wide ? 16'($urandom) : 16'($urandom_range(0, 2000));
    c.single_step_angle = wide ? 16'($urandom) : 16'($urandom_range(0, 4000));
    c.settle_tolerance = wide ? 12'($urandom) : 12'($urandom_range(0, 300));
    c.stall_speed_rpm = 15'($urandom);
    return c;
  endfunction

  // Everything in flight has come back; then allow the pipeline latency
  task automatic wait_drained();
    while (feed_items.size() != 0 || in_valid || feed_expect.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_item(logic [1:0] m, logic [1:0] f, logic signed [31:0] meas,
                           logic [31:0] now, logic signed [15:0] rpm);
    in_item_t t;
    t.mode = m;
    t.shot_req = f;
    t.measured_angle = meas;
    t.now_ms = now;
    t.motor_rpm = rpm;
    feed_items.push_back(t);
    queued++;
  endtask

  task automatic tick(logic [1:0] m, logic [1:0] f, logic signed [31:0] meas,
                      int unsigned dt, logic signed [15:0] rpm);
    gen_now += dt;
    push_item(m, f, meas, gen_now, rpm);
  endtask

  function automatic int jitter();
    int t;
    t = int'(regs.settle_tolerance);
    return int'($urandom_range(0, 2 * t + 2)) - (t + 1);
  endfunction

  // Speed either side of the stall threshold
  function automatic logic signed [15:0] pick_rpm();
    int lo, hi, v;
    if ($urandom_range(0, 1)) begin
      lo = int'(regs.stall_speed_rpm);
      hi = 32767;
    end else begin
      lo = -32768;
      hi = int'(regs.stall_speed_rpm) - 1;
    end
    v = lo + int'($urandom_range(0, hi - lo));
    return v[15:0];
  endfunction

  function automatic logic [1:0] pick_fire();
    return ($urandom_range(0, 9) < 7) ? FIRE_NONE : 2'($urandom_range(0, 3));
  endfunction

  // Mostly complete shots, jams and rapid bursts, the rest mode exits and noise
  task automatic queue_feed_traffic(int n);
    int stop_at, roll, span;
    logic signed [31:0] aim;
    stop_at = queued + n;
    while (queued < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        // single shot, then ticks near its step target
        tick(MODE_START, FIRE_SINGLE, gen_pos, $urandom_range(1, 20), pick_rpm());
        tick(MODE_START, pick_fire(), gen_pos, $urandom_range(1, 20), pick_rpm());
        aim = gen_pos - int'(regs.single_step_angle);
        repeat ($urandom_range(1, 4))
          tick(MODE_START, pick_fire(), aim + jitter(), $urandom_range(1, 30), pick_rpm());
        gen_pos = aim;
      end else if (roll < 55) begin
        // single shot that jams, backs off, then retries or gives up
        span = int'(regs.jam_timeout_ms) / 3 + 1;
        tick(MODE_START, FIRE_SINGLE, gen_pos, $urandom_range(1, 20), pick_rpm());
        tick(MODE_START, pick_fire(), gen_pos, $urandom_range(1, 20), pick_rpm());
        repeat (4) tick(MODE_START, pick_fire(), gen_pos, span, pick_rpm());
        aim = gen_pos + int'(regs.retreat_angle);
        if ($urandom_range(0, 2) != 0) begin
          repeat (2) tick(MODE_START, pick_fire(), aim + jitter(), $urandom_range(1, 30), 0);
          aim = aim - int'(regs.single_step_angle);
          repeat ($urandom_range(1, 3))
            tick(MODE_START, pick_fire(), aim + jitter(), $urandom_range(1, 30), 0);
          gen_pos = aim;
        end else begin
          repeat (2) tick(MODE_START, pick_fire(), gen_pos,
                          int'(regs.backoff_time_ms) / 2 + 1, pick_rpm());
        end
      end else if (roll < 80) begin
        // rapid burst, timed out or stopped
        span = int'(regs.jam_timeout_ms) / 3 + 2;
        tick(MODE_START, FIRE_RAPID, gen_pos, $urandom_range(1, 20), pick_rpm());
        repeat ($urandom_range(3, 10)) begin
          gen_pos = gen_pos - int'(regs.rapid_step_angle) / 2;
          tick(MODE_START, ($urandom_range(0, 4) == 0) ? FIRE_STOP : FIRE_RAPID,
               gen_pos + jitter(), $urandom_range(0, span), pick_rpm());
        end
        tick(MODE_START, FIRE_STOP, gen_pos, $urandom_range(0, span), pick_rpm());
      end else if (roll < 90) begin
        // leave the running mode
        tick(($urandom_range(0, 1) != 0) ? MODE_STOP :
             (($urandom_range(0, 1) != 0) ? MODE_RELAX : MODE_UNUSED),
             2'($urandom_range(0, 3)), gen_pos + jitter(), $urandom_range(0, 50), pick_rpm());
      end else begin
        // raw noise over every field
        tick(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom, $urandom,
             16'($urandom));
      end
    end
  endtask

  int send_plan[4] = '{0, 68, 0, 26};
  int stall_plan[4] = '{0, 0, 68, 26};

  initial begin
    cfg_t c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks under reset settings
    push_item(MODE_RELAX, FIRE_NONE, 1000, 0, 0);
    push_item(MODE_UNUSED, FIRE_SINGLE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 16'sh7FFF);
    push_item(MODE_STOP, FIRE_RAPID, 32'sh8000_0000, 0, 16'sh8000);
    push_item(MODE_START, FIRE_NONE, 0, 10, 0);
    push_item(MODE_START, FIRE_STOP, 0, 20, 0);
    push_item(MODE_START, FIRE_SINGLE, 32'sh8000_0005, 30, 0);
    // step saturates low; stamp just below the counter wrap
    push_item(MODE_START, FIRE_NONE, 32'sh8000_0005, 32'hFFFF_FF00, 0);
    // timeout across the wrap, backoff saturates high
    push_item(MODE_START, FIRE_NONE, 32'sh7FFF_FD78, 32'h0000_0100, 0);
    push_item(MODE_START, FIRE_NONE, 32'sh7FFF_FFF5, 32'h0000_0110, 0);
    push_item(MODE_START, FIRE_NONE, 5000, 32'h0000_0200, 0);
    push_item(MODE_START, FIRE_RAPID, 4040, 32'h0000_0300, 0);
    push_item(MODE_START, FIRE_RAPID, 0, 1000, 0);
    push_item(MODE_START, FIRE_NONE, 100, 1200, 16'sh7FFF);
    // timed out but still fast: stop fire is not obeyed
    push_item(MODE_START, FIRE_STOP, 100, 1600, 16'sh7FFF);
    push_item(MODE_START, FIRE_STOP, 100, 1700, 5000);
    push_item(MODE_START, FIRE_NONE, 100, 1800, 4999);
    push_item(MODE_START, FIRE_NONE, 0, 2301, 0);
    push_item(MODE_START, FIRE_RAPID, 0, 3000, 0);
    push_item(MODE_START, FIRE_STOP, 0, 3100, 16'sh8000);
    push_item(MODE_START, FIRE_RAPID, 0, 3200, 0);
    // negative speed compares below the threshold
    push_item(MODE_START, FIRE_SINGLE, 50, 3701, 16'sh8000);
    push_item(MODE_START, FIRE_NONE, 1010, 3702, 0);
    push_item(MODE_START, FIRE_NONE, 1010, 3703, 0);
    push_item(MODE_START, FIRE_NONE, 60, 3704, 0);
    push_item(MODE_RELAX, FIRE_RAPID, -1, 3705, 0);

    // Random phases: each its own settings and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: c = '{JAM_TIMEOUT_RST, BACKOFF_TIME_RST, RETREAT_ANGLE_RST, RAPID_STEP_RST,
                 SINGLE_STEP_RST, SETTLE_TOL_RST, STALL_SPEED_RST};
        1: c = '0;
        2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 15'h7FFF};
        default: c = random_settings();
      endcase
      apply_config(c);
      send_idle_pct = send_plan[p % 4];
      stall_pct = stall_plan[p % 4];
      gen_now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                             : $urandom;
      case ($urandom_range(0, 3))
        0: gen_pos = 32'sh7FFF_F000 + $urandom_range(0, 4000);
        1: gen_pos = 32'sh8000_0000 + $urandom_range(0, 4000);
        default: gen_pos = int'($urandom_range(0, 200000)) - 100000;
      endcase
      // receiver holds off while the sender keeps offering
      if (p == 4) hold_order++;
      queue_feed_traffic(70);
      // sender pauses until every result is back
      wait_drained();
      queue_feed_traffic(70);
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Run covered %0d ticks and %0d checked results over %0d register settings,",
             n_in, n_out, n_settings);
    $display("with jams, backoffs, rapid bursts, counter wraps, stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("** feeder_step_jam_recovery_fsm: PASSED **");
    end else begin
      $display("** feeder_step_jam_recovery_fsm: FAILED **");
    end
    $finish;
  end

endmodule
